/* sv/bb_pkg.sv */
// Shared types, constants and the reciprocal table of the 3x3 box blur.
`default_nettype none
package bb_pkg;

  // Field and register widths.
  localparam int unsigned CH_W    = 8;
  localparam int unsigned PIX_W   = 3 * CH_W;
  localparam int unsigned FW_W    = 11;
  localparam int unsigned FH_W    = 13;
  localparam int unsigned APB_AW  = 3;
  localparam int unsigned APB_DW  = 32;

  // Averaging arithmetic: sums of up to nine channels, neighbor counts up to nine.
  localparam int unsigned SUM_W   = 12;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned NUM_W   = SUM_W + 1;
  localparam int unsigned REC_SH  = 18;
  localparam int unsigned REC_W   = REC_SH;
  localparam int unsigned PROD_W  = NUM_W + REC_W;

  // Register indexes, decoded from paddr bit 2.
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // Reset values of the registers.
  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(1024);
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(1024);

  typedef logic [PIX_W-1:0] bb_pix_t;

  // Window: [row][column], row 0 is the oldest line.
  typedef logic [2:0][2:0][PIX_W-1:0] bb_win_t;

  // Which window rows and columns lie inside the frame.
  typedef struct packed {
    logic [2:0] row_ok;
    logic [2:0] col_ok;
  } bb_mask_t;

  // ceil(2^18 / (2*count)): exact floor division for numerators below 2^13.
  function automatic logic [REC_W-1:0] bb_recip(input logic [CNT_W-1:0] count);
    logic [REC_W-1:0] m;
    case (count)
      CNT_W'(1): m = REC_W'(131072);
      CNT_W'(2): m = REC_W'(65536);
      CNT_W'(3): m = REC_W'(43691);
      CNT_W'(4): m = REC_W'(32768);
      CNT_W'(5): m = REC_W'(26215);
      CNT_W'(6): m = REC_W'(21846);
      CNT_W'(7): m = REC_W'(18725);
      CNT_W'(8): m = REC_W'(16384);
      CNT_W'(9): m = REC_W'(14564);
      default:   m = '0;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

/* sv/bb_line_store.sv */
// Line store memory: upper and middle lines side by side, registered read.
`default_nettype none
module bb_line_store #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire logic                       clk,
  input  wire logic                       rd_en,
  input  wire logic [AW-1:0]              rd_addr,
  output logic      [2*bb_pkg::PIX_W-1:0] rd_data,
  input  wire logic                       wr_en,
  input  wire logic [AW-1:0]              wr_addr,
  input  wire logic [2*bb_pkg::PIX_W-1:0] wr_data
);
  import bb_pkg::*;

  logic [2*PIX_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* sv/bb_avg_unit.sv */
// Two-stage averaging unit: masked sums and count, then reciprocal multiply.
`default_nettype none
module bb_avg_unit (
  input  wire logic                  clk,
  input  wire bb_pkg::bb_win_t       win,
  input  wire bb_pkg::bb_mask_t      mask,
  output logic [bb_pkg::CH_W-1:0]    avg_red,
  output logic [bb_pkg::CH_W-1:0]    avg_green,
  output logic [bb_pkg::CH_W-1:0]    avg_blue
);
  import bb_pkg::*;

  logic [2:0][SUM_W-1:0]  sum_nxt;
  logic [2:0][SUM_W-1:0]  sum_r;
  logic [CNT_W-1:0]       cnt_nxt;
  logic [CNT_W-1:0]       cnt_r;
  logic [2:0][PROD_W-1:0] prod_nxt;
  logic [2:0][PROD_W-1:0] prod_r;
  logic [REC_W-1:0]       recip;
  logic [NUM_W-1:0]       num;

  // Stage one: add the channels of every window pixel that lies inside the frame.
  always_comb begin
    sum_nxt = '0;
    cnt_nxt = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (mask.row_ok[r] && mask.col_ok[c]) begin
          for (int ch = 0; ch < 3; ch++) begin
            sum_nxt[ch] = sum_nxt[ch] +
                          SUM_W'(win[r][c][(2-ch)*CH_W +: CH_W]);
          end
          cnt_nxt = cnt_nxt + CNT_W'(1);
        end
      end
    end
  end

  // Stage two: (2*sum + count) / (2*count) as a multiply by the reciprocal.
  always_comb begin
    recip = bb_recip(cnt_r);
    num   = '0;
    for (int ch = 0; ch < 3; ch++) begin
      num          = {sum_r[ch], 1'b0} + NUM_W'(cnt_r);
      prod_nxt[ch] = PROD_W'(num) * PROD_W'(recip);
    end
  end

  always_ff @(posedge clk) begin
    sum_r  <= sum_nxt;
    cnt_r  <= cnt_nxt;
    prod_r <= prod_nxt;
  end

  assign avg_red   = prod_r[0][REC_SH +: CH_W];
  assign avg_green = prod_r[1][REC_SH +: CH_W];
  assign avg_blue  = prod_r[2][REC_SH +: CH_W];

endmodule
`default_nettype wire

/* sv/box_blur_3x3_edge_average_unit.sv */
// Top level of the streaming 3x3 box blur with edge-aware averaging.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_ready  | in_mode, in_pix_red/green/blue
//   out     | output    | out_valid/out_ready| out_red/green/blue, out_frame_last
//   cfg     | input     | APB psel/penable   | frame_width @0x0, frame_height @0x4
//
// A pixel item passes through line store read and then write-back and window
// shift; one that gives a result goes on through two averaging stages and the
// output load. A drain item that first steps over a non-emitting position
// runs read and write-back again; the line store read-modify-write sets these steps.
// Reset is synchronous; no clearing pass runs. The input side is held only
// while an item is in work; a finished result waits in the output register.
`default_nettype none
module box_blur_3x3_edge_average_unit #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // Input items.
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_mode,
  input  wire logic [bb_pkg::CH_W-1:0]     in_pix_red,
  input  wire logic [bb_pkg::CH_W-1:0]     in_pix_green,
  input  wire logic [bb_pkg::CH_W-1:0]     in_pix_blue,
  // Result items.
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [bb_pkg::CH_W-1:0]          out_red,
  output logic [bb_pkg::CH_W-1:0]          out_green,
  output logic [bb_pkg::CH_W-1:0]          out_blue,
  output logic                             out_frame_last,
  // Configuration port.
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bb_pkg::APB_AW-1:0]   paddr,
  input  wire logic [bb_pkg::APB_DW-1:0]   pwdata,
  output logic [bb_pkg::APB_DW-1:0]        prdata,
  output logic                             pready
);
  import bb_pkg::*;

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_WB,
    ST_SUM,
    ST_DIV,
    ST_OUT
  } state_t;

  state_t           state_r;
  logic [FW_W-1:0]  frame_width_r;
  logic [FH_W-1:0]  frame_height_r;
  logic [CW-1:0]    w_eff;
  logic [RW-1:0]    h_eff;
  logic [CW-1:0]    in_col_r;
  logic [RW-1:0]    in_row_r;
  logic [CW-1:0]    out_col_r;
  logic [RW-1:0]    out_row_r;
  logic [CW-1:0]    in_col_inc;
  logic [RW-1:0]    out_row_inc;
  logic [CW-1:0]    out_col_inc;
  bb_pix_t          pix_r;
  logic             drain_r;
  logic             second_r;
  logic             last_r;
  bb_win_t          win_r;
  bb_mask_t         mask_r;
  logic             emit;
  logic             last_now;
  logic             cfg_wr;
  logic             in_acc;
  logic [2*PIX_W-1:0] mem_rd_data;
  bb_pix_t          up_pix;
  bb_pix_t          mid_pix;
  logic [CH_W-1:0]  avg_red;
  logic [CH_W-1:0]  avg_green;
  logic [CH_W-1:0]  avg_blue;

  // Configuration registers and read-back.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_FRAME_WIDTH) begin
        frame_width_r <= pwdata[FW_W-1:0];
      end else begin
        frame_height_r <= pwdata[FH_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_FRAME_HEIGHT) begin
      prdata = APB_DW'(frame_height_r);
    end else begin
      prdata = APB_DW'(frame_width_r);
    end
  end

  // Effective frame size: zero acts as one, oversize acts as the maximum.
  always_comb begin
    if (frame_width_r == '0) begin
      w_eff = CW'(1);
    end else if (32'(frame_width_r) > 32'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      h_eff = RW'(1);
    end else if (32'(frame_height_r) > 32'(MAX_HEIGHT)) begin
      h_eff = RW'(MAX_HEIGHT);
    end else begin
      h_eff = RW'(frame_height_r);
    end
  end

  // Position bookkeeping for the current raster step.
  assign emit = (in_row_r >= RW'(2)) || ((in_row_r == RW'(1)) && (in_col_r != '0));
  assign last_now = ((RW+1)'(out_row_r) + (RW+1)'(1) >= (RW+1)'(h_eff)) &&
                    ((CW+1)'(out_col_r) + (CW+1)'(1) >= (CW+1)'(w_eff));
  assign in_col_inc  = in_col_r + CW'(1);
  assign out_col_inc = out_col_r + CW'(1);
  assign out_row_inc = out_row_r + RW'(1);

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign up_pix   = mem_rd_data[2*PIX_W-1:PIX_W];
  assign mid_pix  = mem_rd_data[PIX_W-1:0];

  bb_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (state_r == ST_RD),
    .rd_addr (in_col_r[AW-1:0]),
    .rd_data (mem_rd_data),
    .wr_en   (state_r == ST_WB),
    .wr_addr (in_col_r[AW-1:0]),
    .wr_data ({mid_pix, pix_r})
  );

  bb_avg_unit u_avg (
    .clk       (clk),
    .win       (win_r),
    .mask      (mask_r),
    .avg_red   (avg_red),
    .avg_green (avg_green),
    .avg_blue  (avg_blue)
  );

  // Sequencer, counters, window and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      drain_r   <= 1'b0;
      second_r  <= 1'b0;
      last_r    <= 1'b0;
      win_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            second_r <= 1'b0;
            if (in_row_r < h_eff) begin
              drain_r <= 1'b0;
              pix_r   <= {in_pix_red, in_pix_green, in_pix_blue};
              if (!in_mode) begin
                state_r <= ST_RD;
              end
            end else begin
              drain_r <= 1'b1;
              pix_r   <= '0;
              state_r <= ST_RD;
            end
          end
        end
        ST_RD: begin
          state_r <= ST_WB;
        end
        ST_WB: begin
          // Shift the window and take in the new column.
          for (int k = 0; k < 3; k++) begin
            win_r[k][0] <= win_r[k][1];
            win_r[k][1] <= win_r[k][2];
          end
          win_r[0][2] <= up_pix;
          win_r[1][2] <= mid_pix;
          win_r[2][2] <= pix_r;
          // Neighbors of the output position that lie inside the frame.
          mask_r.row_ok <= {(RW+1)'(out_row_r) + (RW+1)'(1) < (RW+1)'(h_eff), 1'b1,
                            out_row_r != '0};
          mask_r.col_ok <= {(CW+1)'(out_col_r) + (CW+1)'(1) < (CW+1)'(w_eff), 1'b1,
                            out_col_r != '0};
          if (in_col_inc >= w_eff) begin
            in_col_r <= '0;
            in_row_r <= in_row_r + RW'(1);
          end else begin
            in_col_r <= in_col_inc;
          end
          if (emit) begin
            last_r <= last_now;
            if (out_col_inc >= w_eff) begin
              out_col_r <= '0;
              out_row_r <= out_row_inc;
            end else begin
              out_col_r <= out_col_inc;
            end
            if (last_now) begin
              in_col_r  <= '0;
              in_row_r  <= '0;
              out_col_r <= '0;
              out_row_r <= '0;
            end
            state_r <= ST_SUM;
          end else if (drain_r && !second_r) begin
            second_r <= 1'b1;
            state_r  <= ST_RD;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_SUM: begin
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            out_red        <= avg_red;
            out_green      <= avg_green;
            out_blue       <= avg_blue;
            out_frame_last <= last_r;
            state_r        <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
      // A register write restarts the frame.
      if (cfg_wr) begin
        in_col_r  <= '0;
        in_row_r  <= '0;
        out_col_r <= '0;
        out_row_r <= '0;
      end
    end
  end

endmodule
`default_nettype wire

/* sv/bb_checker.sv */
// Port-level checker for the box blur, bound to the top level.
`default_nettype none
module bb_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_red,
  input wire logic [7:0] out_green,
  input wire logic [7:0] out_blue,
  input wire logic       out_frame_last,
  input wire logic       pready
);

  // A result that is not taken holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green) &&
                                $stable(out_blue) && $stable(out_frame_last))
    else $error("result changed while stalled");

  // Reset leaves no result pending and the input open.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("state after reset is wrong");

  // The configuration port never inserts wait states.
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("pready low");

  // A new result only appears when the input side is open again.
  a_rise_ready: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result loaded while an item is still in work");

endmodule

bind box_blur_3x3_edge_average_unit bb_checker u_bb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_red        (out_red),
  .out_green      (out_green),
  .out_blue       (out_blue),
  .out_frame_last (out_frame_last),
  .pready         (pready)
);
`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench for the streaming 3x3 edge-average box blur.
module tb_top;
  import bb_pkg::*;

  localparam int unsigned LINE_MAX  = 1024;
  localparam int unsigned ROWS_MAX  = 4096;
  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned STALL_LIMIT   = 3000;
  localparam int unsigned HOLD_CYCLES   = 400;

  typedef struct {
    logic           mode;
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } blur_item_t;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
    logic            last;
  } blur_pixel_t;

  logic clk;
  logic rst_n;
  logic in_valid, in_ready, in_mode;
  logic [CH_W-1:0] in_pix_red, in_pix_green, in_pix_blue;
  logic out_valid, out_ready;
  logic [CH_W-1:0] out_red, out_green, out_blue;
  logic out_frame_last;
  logic psel, penable, pwrite, pready;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata, prdata;

  box_blur_3x3_edge_average_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_pix_red(in_pix_red), .in_pix_green(in_pix_green), .in_pix_blue(in_pix_blue),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .out_frame_last(out_frame_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Clock with a 4 unit period.
  always begin
    clk = 1'b0; #2;
    clk = 1'b1; #2;
  end

  // Predictor state: a private copy of the blur pipeline.
  int unsigned width_reg, height_reg;
  logic [PIX_W-1:0] upper_line [LINE_MAX];
  logic [PIX_W-1:0] middle_line [LINE_MAX];
  logic [PIX_W-1:0] blur_win [3][3];
  int unsigned in_col, in_row, out_col, out_row;

  blur_item_t  pending_items[$];
  blur_pixel_t expected_pixels[$];

  int errors, items_in, results_out, frames_done, writes_done;
  bit no_idle;
  int hold_reqs, hold_seen, hold_left;
  int stall_cycles;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned max);
    if (v == 0) return 1;
    return (v > max) ? max : v;
  endfunction

  function automatic void restart_frame();
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
  endfunction

  // Rounded average over the in-frame neighbors of the current output position.
  function automatic blur_pixel_t window_average(int ccol, int w, int h);
    blur_pixel_t res;
    int sr, sg, sb, cnt, r, c, wc;
    sr = 0; sg = 0; sb = 0; cnt = 0;
    res = '0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        r = int'(out_row) + dr;
        c = int'(out_col) + dc;
        wc = ccol + dc;
        if (r < 0 || c < 0 || r >= h || c >= w || wc < 0 || wc > 2) continue;
        sr += blur_win[dr+1][wc][23:16];
        sg += blur_win[dr+1][wc][15:8];
        sb += blur_win[dr+1][wc][7:0];
        cnt++;
      end
    end
    if (cnt != 0) begin
      res.r = CH_W'((2*sr + cnt) / (2*cnt));
      res.g = CH_W'((2*sg + cnt) / (2*cnt));
      res.b = CH_W'((2*sb + cnt) / (2*cnt));
    end
    return res;
  endfunction

  // One raster position: shift the window, rotate line stores, maybe emit.
  function automatic bit raster_advance(logic [PIX_W-1:0] pix, output blur_pixel_t res);
    int unsigned w, h, ic, ir;
    bit emit;
    logic [PIX_W-1:0] up, mid;
    w = clamp_dim(width_reg, LINE_MAX);
    h = clamp_dim(height_reg, ROWS_MAX);
    ic = in_col; ir = in_row;
    emit = (ir >= 2) || (ir == 1 && ic >= 1);
    res = '0;
    if (emit && ic == 0) res = window_average(2, w, h);
    up = upper_line[ic];
    mid = middle_line[ic];
    upper_line[ic] = mid;
    middle_line[ic] = pix;
    for (int k = 0; k < 3; k++) begin
      blur_win[k][0] = blur_win[k][1];
      blur_win[k][1] = blur_win[k][2];
    end
    blur_win[0][2] = up;
    blur_win[1][2] = mid;
    blur_win[2][2] = pix;
    if (emit && ic != 0) res = window_average(1, w, h);
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (!emit) return 0;
    res.last = (out_row + 1 >= h) && (out_col + 1 >= w);
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
    end
    if (res.last) restart_frame();
    return 1;
  endfunction

  // Works out the result, if any, of one accepted item.
  function automatic void blur_predict(logic mode, logic [PIX_W-1:0] pix);
    blur_pixel_t res;
    bit got;
    if (in_row < clamp_dim(height_reg, ROWS_MAX)) begin
      if (mode == MODE_DRAIN) return;
      got = raster_advance(pix, res);
    end else begin
      got = raster_advance('0, res);
      if (!got) got = raster_advance('0, res);
    end
    if (got) expected_pixels.push_back(res);
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at item result %0d: %s", results_out, what);
    errors++;
  endtask

  // Input driver fed from the queue of pending items.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        blur_predict(in_mode, {in_pix_red, in_pix_green, in_pix_blue});
        items_in++;
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() > 0 && (no_idle || $urandom_range(99) >= 6)) begin
          in_valid     <= 1'b1;
          in_mode      <= pending_items[0].mode;
          in_pix_red   <= pending_items[0].r;
          in_pix_green <= pending_items[0].g;
          in_pix_blue  <= pending_items[0].b;
          void'(pending_items.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor with random and long stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_out++;
        if (expected_pixels.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          if (out_red != expected_pixels[0].r)
            report_mismatch($sformatf("red %0d, want %0d", out_red, expected_pixels[0].r));
          if (out_green != expected_pixels[0].g)
            report_mismatch($sformatf("green %0d, want %0d", out_green,
                                      expected_pixels[0].g));
          if (out_blue != expected_pixels[0].b)
            report_mismatch($sformatf("blue %0d, want %0d", out_blue, expected_pixels[0].b));
          if (out_frame_last != expected_pixels[0].last)
            report_mismatch($sformatf("frame_last %0b, want %0b", out_frame_last,
                                      expected_pixels[0].last));
          if (expected_pixels[0].last) frames_done++;
          void'(expected_pixels.pop_front());
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle || ($urandom_range(99) >= 6);
      end
    end
  end

  // Watchdog on cycles without any accepted item, taken result or register access.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no progress for %0d cycles", stall_cycles);
        $display("[box_blur_3x3_edge_average_unit] ERROR");
        $finish;
      end
    end
  end

  // Register write over the configuration port; the block is idle here.
  task automatic write_reg(logic idx, logic [APB_DW-1:0] data);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0;
    if (idx == REG_FRAME_WIDTH) width_reg = data & 32'h7FF;
    else height_reg = data & 32'h1FFF;
    restart_frame();
    writes_done++;
  endtask

  // Sets both dimensions; noisy upper bits must be ignored.
  task automatic set_dims(int unsigned w, int unsigned h, bit noisy);
    logic [APB_DW-1:0] junk;
    junk = noisy ? $urandom : '0;
    write_reg(REG_FRAME_WIDTH, (junk & ~32'h7FF) | w);
    write_reg(REG_FRAME_HEIGHT, (junk & ~32'h1FFF) | h);
  endtask

  // Waits until every queued item is in and every result has come.
  task automatic wait_idle();
    while (pending_items.size() > 0 || in_valid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void add_item(logic mode, int r, int g, int b);
    blur_item_t it;
    it.mode = mode; it.r = CH_W'(r); it.g = CH_W'(g); it.b = CH_W'(b);
    pending_items.push_back(it);
  endfunction

  // One whole frame of random pixels with some ignored drains, then its drains.
  function automatic void add_frame(int unsigned w, int unsigned h);
    for (int unsigned i = 0; i < w * h; i++) begin
      if ($urandom_range(99) < 4)
        add_item(MODE_DRAIN, $urandom, $urandom, $urandom);
      add_item(MODE_PIXEL, $urandom, $urandom, $urandom);
    end
    for (int unsigned i = 0; i <= w; i++)
      add_item(($urandom_range(3) == 0) ? MODE_PIXEL : MODE_DRAIN,
               $urandom, $urandom, $urandom);
  endfunction

  initial begin
    int unsigned w, h;
    rst_n = 1'b0;
    in_valid = 1'b0; in_mode = MODE_PIXEL;
    in_pix_red = '0; in_pix_green = '0; in_pix_blue = '0;
    out_ready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    width_reg = 1024; height_reg = 1024;
    for (int i = 0; i < LINE_MAX; i++) begin
      upper_line[i] = '0;
      middle_line[i] = '0;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) blur_win[i][j] = '0;
    restart_frame();
    errors = 0; items_in = 0; results_out = 0; frames_done = 0; writes_done = 0;
    no_idle = 1'b0; hold_reqs = 0; hold_seen = 0; hold_left = 0; stall_cycles = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: a 3x3 checkerboard of extremes, a drain inside the frame,
    // post-frame pixels that act as drains, then a one-pixel frame.
    set_dims(3, 3, 0);
    for (int i = 0; i < 9; i++) begin
      if (i == 2) add_item(MODE_DRAIN, 255, 255, 255);
      if (i % 2 == 0) add_item(MODE_PIXEL, 255, 255, 255);
      else add_item(MODE_PIXEL, 0, 0, 0);
    end
    add_item(MODE_DRAIN, 0, 0, 0);
    add_item(MODE_PIXEL, 255, 0, 255);
    add_item(MODE_DRAIN, 255, 255, 255);
    add_item(MODE_PIXEL, 0, 255, 0);
    wait_idle();
    set_dims(0, 0, 0);
    add_item(MODE_PIXEL, 255, 128, 1);
    add_item(MODE_DRAIN, 0, 0, 0);
    add_item(MODE_DRAIN, 0, 0, 0);
    wait_idle();

    // Oversize registers clamp to the maxima; the next write cuts each frame short.
    set_dims(2047, 2, 1);
    for (int i = 0; i < 40; i++) add_item(MODE_PIXEL, $urandom, $urandom, $urandom);
    wait_idle();
    set_dims(1, 8191, 1);
    for (int i = 0; i < 40; i++) add_item(MODE_PIXEL, $urandom, $urandom, $urandom);
    wait_idle();
    set_dims(64, 3, 0);
    add_frame(64, 3);
    wait_idle();

    // Reconfigure in the middle of a frame before any result is due.
    set_dims(5, 5, 0);
    for (int i = 0; i < 3; i++) add_item(MODE_PIXEL, $urandom, $urandom, $urandom);
    wait_idle();

    // Long output hold-off while the sender keeps offering items.
    set_dims(10, 6, 1);
    hold_reqs++;
    add_frame(10, 6);
    wait_idle();

    // A frame fed without any idling, paused halfway until results drain.
    no_idle = 1'b1;
    set_dims(7, 5, 0);
    for (int i = 0; i < 17; i++) add_item(MODE_PIXEL, $urandom, $urandom, $urandom);
    while (pending_items.size() > 0 || in_valid || expected_pixels.size() > 0)
      @(posedge clk);
    for (int i = 17; i < 35; i++) add_item(MODE_PIXEL, $urandom, $urandom, $urandom);
    for (int i = 0; i <= 7; i++) add_item(MODE_DRAIN, 0, 0, 0);
    wait_idle();
    no_idle = 1'b0;

    // Random small frames, some back to back under one setting.
    while (items_in < 1100) begin
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 8);
      set_dims(w, h, 1);
      repeat ($urandom_range(1, 3)) add_frame(w, h);
      wait_idle();
    end

    wait_idle();
    $display("covered %0d items, %0d results, %0d frames, %0d register writes",
             items_in, results_out, frames_done, writes_done);
    $display("frames from 1x1 up to 64 wide, oversize sizes clamped, stalls on both sides");
    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("[box_blur_3x3_edge_average_unit] OK");
    end else begin
      $display("%0d mismatches, %0d results still expected", errors, expected_pixels.size());
      $display("[box_blur_3x3_edge_average_unit] ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
sv/bb_pkg.sv
sv/bb_line_store.sv
sv/bb_avg_unit.sv
sv/box_blur_3x3_edge_average_unit.sv
sv/bb_checker.sv
sim/tb_top.sv
